@@ hdl/xorshift32_range_generator_core_defines.svh @@
// Assertion macros shared by the RTL files
`ifndef XORSHIFT32_RANGE_GENERATOR_CORE_DEFINES_SVH
`define XORSHIFT32_RANGE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define XSRG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define XSRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/xsrg_pkg.sv @@
`default_nettype none

package xsrg_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] SEED_RESET = 32'd2463534242;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_RESEED = 2'd1;
    localparam logic [1:0] REQ_DRAW   = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] range_low;
        logic [DATA_W-1:0] range_high;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] random_value;
        logic [DATA_W-1:0] tick_count;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hdl/xsrg_divider.sv @@
`default_nettype none
`include "xorshift32_range_generator_core_defines.svh"

module xsrg_divider
    import xsrg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvd, n_dvd;
    logic [DATA_W-1:0] r_dvs, n_dvs;

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    logic            fits;

    assign shifted = {r_rem, r_dvd[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // one restoring step per cycle
            n_rem = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

    `XSRG_ASSERT_NEXT(a_start_busy, i_req.start, r_busy)
    `XSRG_ASSERT_IMPL(a_done_idle, r_done, !r_busy)

endmodule

`default_nettype wire

@@ hdl/xorshift32_range_generator_core.sv @@
// channel   valid        stall        payload
// request   i_in_valid   o_in_stall   i_in_data  (t_in)
// result    o_out_valid  i_out_stall  o_out_data (t_out)
//
// Tick, reseed, unused code, empty or full-range draw: r_res, then result register.
// Draw over a partial range: S_DIV, radix-2 remainder unit (32 steps), then S_PUSH.
// One request at a time; the next is taken while a result waits to be taken.
// Reset: seed 2463534242, tick count zero, no result pending.
// A stalled result holds; a finished request waits until the result register is free.
`default_nettype none
`include "xorshift32_range_generator_core_defines.svh"

module xorshift32_range_generator_core
    import xsrg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_seed, n_seed;
    logic [DATA_W-1:0] r_tick, n_tick;
    logic [DATA_W-1:0] r_low, n_low;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out              r_out_data, n_out_data;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              in_accept;
    logic [DATA_W-1:0] stepped;
    logic [DATA_W-1:0] span;

    function automatic logic [DATA_W-1:0] xs_step(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign stepped    = xs_step(r_seed);
    assign span       = i_in_data.range_high - i_in_data.range_low + 1'b1;

    always_comb begin
        n_state          = r_state;
        n_seed           = r_seed;
        n_tick           = r_tick;
        n_low            = r_low;
        n_res            = r_res;
        n_out_valid      = r_out_valid && i_out_stall;
        n_out_data       = r_out_data;
        div_req.start    = 1'b0;
        div_req.dividend = stepped;
        div_req.divisor  = span;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res   = '0;
                    n_state = S_PUSH;
                    unique case (i_in_data.req_type)
                        REQ_TICK: begin
                            n_tick = r_tick + 1'b1;
                        end
                        REQ_RESEED: begin
                            n_seed = r_tick;
                        end
                        REQ_DRAW: begin
                            if (i_in_data.range_high <= i_in_data.range_low) begin
                                n_res = i_in_data.range_low;
                            end else begin
                                n_seed = stepped;
                                if (span == '0) begin
                                    n_res = stepped;
                                end else begin
                                    div_req.start = 1'b1;
                                    n_low         = i_in_data.range_low;
                                    n_state       = S_DIV;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = r_low + div_rsp.remainder;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.random_value = r_res;
                    n_out_data.tick_count   = r_tick;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    xsrg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `XSRG_ASSERT_NEXT(a_accept_leaves_idle, in_accept, r_state != S_IDLE)
    `XSRG_ASSERT_IMPL(a_done_in_div, div_rsp.done, r_state == S_DIV)

endmodule

`default_nettype wire
